[src/seven_segment_scan_driver_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment scan driver
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define SSS_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// When the trigger holds, the consequence holds at the next clock edge.
`define SSS_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Types, constants and the character table of the seven-segment scan driver.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

  localparam int Digits = 4;
  localparam int PosW   = (Digits > 1) ? $clog2(Digits) : 1;
  localparam int SelW   = 4;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0]      DIV_RESET      = 8'd10;
  localparam logic [7:0]      TICK_RESET     = 8'd15;
  localparam logic [PosW-1:0] POS_RESET      = PosW'(1 % Digits);
  localparam logic [7:0]      CLEAR_SEGMENTS = 8'h39;
  localparam logic [SelW-1:0] CLEAR_SELECT   = 4'hB;

  typedef struct packed {
    logic [7:0]      segments;
    logic [SelW-1:0] digit_select;
  } sss_result_t;

  // Segment code of an ASCII character; anything not in the table is blank.
  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    logic [7:0] g;
    case (c)
      8'h30:   g = 8'h3F;  // '0'
      8'h31:   g = 8'h06;
      8'h32:   g = 8'h5B;
      8'h33:   g = 8'h4F;
      8'h34:   g = 8'h66;
      8'h35:   g = 8'h6D;
      8'h36:   g = 8'h7D;
      8'h37:   g = 8'h07;
      8'h38:   g = 8'h7F;
      8'h39:   g = 8'h6F;  // '9'
      8'h61:   g = 8'h77;  // 'a'
      8'h62:   g = 8'h7C;
      8'h63:   g = 8'h39;
      8'h64:   g = 8'h5E;  // 'd'
      8'h2A:   g = 8'h46;  // '*'
      8'h23:   g = 8'h70;  // '#'
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[src/sss_cmd_if.sv]
// ----------------------------------------------------------------------------
// sss_cmd_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sss_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic [1:0] digit_index;

  modport source (output valid, output cmd, output char_code, output digit_index,
                  input ready);
  modport sink   (input valid, input cmd, input char_code, input digit_index,
                  output ready);
endinterface

`default_nettype wire

[src/sss_res_if.sv]
// ----------------------------------------------------------------------------
// sss_res_if
// Result channel: valid/ready handshake carrying segment and select latches.
// ----------------------------------------------------------------------------
`default_nettype none

interface sss_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [3:0] digit_select;

  modport source (output valid, output segments, output digit_select, input ready);
  modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

`default_nettype wire

[src/sss_core.sv]
// ----------------------------------------------------------------------------
// sss_core
// Digit store, tick divider, scan position and display latches.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                accept_i,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          char_code_i,
  input  logic [1:0]          digit_index_i,
  output sss_pkg::sss_result_t res_o
);
  import sss_pkg::*;

  logic [7:0]      div_q;
  logic [7:0]      codes_q [Digits];
  logic [7:0]      codes_d [Digits];
  logic [7:0]      tick_q, tick_d, tick_dec;
  logic [PosW-1:0] pos_q, pos_d, pos_next, wr_addr;
  logic [7:0]      seg_q, seg_d;
  logic [SelW-1:0] sel_q, sel_d, sel_of_pos;

  assign tick_dec = tick_q - 8'd1;
  assign pos_next = (pos_q == PosW'(Digits - 1)) ? '0 : pos_q + PosW'(1);
  assign wr_addr  = PosW'(digit_index_i);

  // Select bits above the field width stay high for digits beyond it.
  always_comb begin
    for (int k = 0; k < SelW; k++) begin
      sel_of_pos[k] = !(32'(pos_q) == k);
    end
  end

  always_comb begin
    codes_d = codes_q;
    tick_d  = tick_q;
    pos_d   = pos_q;
    seg_d   = seg_q;
    sel_d   = sel_q;
    if (accept_i) begin
      unique case (cmd_i)
        CMD_TICK: begin
          if (tick_dec == 8'd0) begin
            tick_d = div_q;
            seg_d  = codes_q[pos_q];
            sel_d  = sel_of_pos;
            pos_d  = pos_next;
          end else begin
            tick_d = tick_dec;
          end
        end
        CMD_SET: begin
          if (32'(digit_index_i) < Digits) begin
            codes_d[wr_addr] = glyph_of(char_code_i);
          end
        end
        CMD_CLEAR: begin
          for (int k = 0; k < Digits; k++) begin
            codes_d[k] = 8'h00;
          end
          seg_d = CLEAR_SEGMENTS;
          sel_d = CLEAR_SELECT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= DIV_RESET;
      tick_q <= TICK_RESET;
      pos_q  <= POS_RESET;
      seg_q  <= CLEAR_SEGMENTS;
      sel_q  <= CLEAR_SELECT;
      for (int k = 0; k < Digits; k++) begin
        codes_q[k] <= 8'h00;
      end
    end else begin
      if (cfg_we_i) begin
        div_q <= cfg_wdata_i;
      end
      tick_q  <= tick_d;
      pos_q   <= pos_d;
      seg_q   <= seg_d;
      sel_q   <= sel_d;
      codes_q <= codes_d;
    end
  end

  // The result of an item is the latch pair as it stands after the item.
  assign res_o.segments     = seg_d;
  assign res_o.digit_select = sel_d;

endmodule

`default_nettype wire

[src/sss_out_reg.sv]
// ----------------------------------------------------------------------------
// sss_out_reg
// Result register that holds one item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  sss_pkg::sss_result_t res_i,
  output logic                 can_load_o,
  sss_res_if.source            out_o
);
  import sss_pkg::*;

  logic        valid_q;
  sss_result_t data_q;

  // A new item may enter while the held one leaves in the same cycle.
  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.segments     = data_q.segments;
  assign out_o.digit_select = data_q.digit_select;

endmodule

`default_nettype wire

[src/seven_segment_scan_driver.sv]
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Four-digit multiplexed seven-segment driver with a tick-driven digit scan.
// ----------------------------------------------------------------------------
// Each command item (tick, set character, clear) updates the digit store and
// the segment/select latches in the cycle it is accepted, and one result item
// carrying both latches appears in the result register on the next cycle. The
// block takes one item per clock for as long as the result side keeps up; a
// stalled result holds it back only while the result register is full and not
// being read. A tick moves the scan to the next digit every scan_divisor ticks;
// the divisor is written through cfg_we_i/cfg_wdata_i and takes effect at the
// next reload.
`default_nettype none

`include "seven_segment_scan_driver_macros.svh"

module seven_segment_scan_driver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  sss_cmd_if.sink    in_i,
  sss_res_if.source  out_o
);
  import sss_pkg::*;

  logic        can_load;
  logic        accept;
  sss_result_t res;

  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  sss_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .cmd_i         (in_i.cmd),
    .char_code_i   (in_i.char_code),
    .digit_index_i (in_i.digit_index),
    .res_o         (res)
  );

  sss_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

  `SSS_ASSERT_NEXT(a_accept_gives_result, accept, out_o.valid)
  `SSS_ASSERT_NOW(a_ready_tracks_room, in_i.ready == (!out_o.valid || out_o.ready))
  `SSS_ASSERT_NOW(a_one_digit_selected, !out_o.valid || $countones(~out_o.digit_select) <= 1)

endmodule

`default_nettype wire
